// ===== src/gbbd_pkg.sv =====
package gbbd_pkg;

    localparam int DIM_W         = 13;
    localparam int CNT_W         = 12;
    localparam int CFG_ADDR_W    = 5;
    localparam int MAX_DIM_DEF   = 4096;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [26:0] LAYOUT_RESET = 27'd45252779;
    localparam logic [1:0]  DEPTH_16     = 2'd0;
    localparam logic [1:0]  DEPTH_24     = 2'd1;
    localparam logic [3:0]  IDX_LAST     = 4'd11;

    typedef enum logic [2:0] {
        REG_BOX_WIDTH,
        REG_BOX_HEIGHT,
        REG_COLOR_UL,
        REG_COLOR_UR,
        REG_COLOR_LL,
        REG_COLOR_LR,
        REG_LAYOUT,
        REG_MODE
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0] box_width;
        logic [DIM_W-1:0] box_height;
        logic [31:0]      color_ul;
        logic [31:0]      color_ur;
        logic [31:0]      color_ll;
        logic [31:0]      color_lr;
        logic [26:0]      layout;
        logic [5:0]       mode;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_ROW_INIT,
        S_ACC,
        S_BLEND,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       capture;
        logic       div_start;
        logic       div_store;
        logic [3:0] div_idx;
        logic       row_init;
        logic       acc_step;
        logic       blend;
        logic       commit;
    } t_cmd;

    typedef struct packed {
        logic row_start;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ===== src/gradient_box_blend_dither.sv =====
// Channel   Direction  Payload
// s         in         tdata background pixel, tuser first pixel of the box
// m         out        tdata new pixel, tlast end of row, tuser end of box
// apb       in/out     configuration registers at byte address 4*i
//
// A pixel is captured, then stepped through the accumulators and the blend, and its result is loaded
// into the output register; the next pixel is taken once the result is in the output register.
// The first pixel of a row adds twelve divisions, each started and then awaited, and a step
// that loads the accumulators before the pixel is stepped and blended.
// Reset is synchronous and active low and clears the controller, counters and output valid.
// A stalled output holds the result and the controller waits before committing the next.
module gradient_box_blend_dither
    import gbbd_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [31:0]           i_s_tdata,  // background_pixel
    input  logic                  i_s_tuser,  // first_of_box
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [31:0]           o_m_tdata,  // pixel_value
    output logic                  o_m_tlast,
    output logic                  o_m_tuser,  // end_of_box
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg     r_cfg;
    t_cmd     cmd;
    t_status  status;
    t_reg_idx reg_idx;

    assign reg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_width  <= DIM_W'(1);
            r_cfg.box_height <= DIM_W'(1);
            r_cfg.color_ul   <= '0;
            r_cfg.color_ur   <= '0;
            r_cfg.color_ll   <= '0;
            r_cfg.color_lr   <= '0;
            r_cfg.layout     <= LAYOUT_RESET;
            r_cfg.mode       <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_BOX_WIDTH:  r_cfg.box_width  <= pwdata[DIM_W-1:0];
                REG_BOX_HEIGHT: r_cfg.box_height <= pwdata[DIM_W-1:0];
                REG_COLOR_UL:   r_cfg.color_ul   <= pwdata;
                REG_COLOR_UR:   r_cfg.color_ur   <= pwdata;
                REG_COLOR_LL:   r_cfg.color_ll   <= pwdata;
                REG_COLOR_LR:   r_cfg.color_lr   <= pwdata;
                REG_LAYOUT:     r_cfg.layout     <= pwdata[26:0];
                REG_MODE:       r_cfg.mode       <= pwdata[5:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BOX_WIDTH:  prdata = 32'(r_cfg.box_width);
            REG_BOX_HEIGHT: prdata = 32'(r_cfg.box_height);
            REG_COLOR_UL:   prdata = r_cfg.color_ul;
            REG_COLOR_UR:   prdata = r_cfg.color_ur;
            REG_COLOR_LL:   prdata = r_cfg.color_ll;
            REG_COLOR_LR:   prdata = r_cfg.color_lr;
            REG_LAYOUT:     prdata = 32'(r_cfg.layout);
            REG_MODE:       prdata = 32'(r_cfg.mode);
            default:        prdata = '0;
        endcase
    end

    gbbd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    gbbd_datapath #(
        .MAX_DIM  (MAX_DIM),
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd     (cmd),
        .o_status  (status),
        .i_bg      (i_s_tdata),
        .i_first   (i_s_tuser),
        .i_m_tready(i_m_tready),
        .o_m_tvalid(o_m_tvalid),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast),
        .o_m_tuser (o_m_tuser)
    );

endmodule

// ===== src/gbbd_divider.sv =====
module gbbd_divider
    import gbbd_pkg::*;
#(
    parameter int NUM_W = 24,
    parameter int DEN_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_done
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] diff;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_quo[NUM_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
        n_rem   = diff[DEN_W+1] ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[NUM_W-2:0], ~diff[DEN_W+1]};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

// ===== src/gbbd_datapath.sv =====
module gbbd_datapath
    import gbbd_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [31:0] i_bg,
    input  logic        i_first,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output logic [31:0] o_m_tdata,
    output logic        o_m_tlast,
    output logic        o_m_tuser
);

    localparam int NUM_W  = (8 + FRAC_BITS > DIM_W + 9) ? 8 + FRAC_BITS : DIM_W + 9;
    localparam int STEP_W = FRAC_BITS + 9;
    localparam int ACC_W  = FRAC_BITS + 8 + CNT_W + 2;

    logic [CNT_W-1:0]        r_col;
    logic [CNT_W-1:0]        r_row;
    logic [31:0]             r_bg;
    logic [7:0]              r_e1 [4];
    logic [7:0]              r_e2 [4];
    logic signed [STEP_W-1:0] r_step [4];
    logic signed [ACC_W-1:0] r_acc [4];
    logic [7:0]              r_chan [4];
    logic [7:0]              r_mix [3];
    logic [1:0]              r_phase;
    logic                    r_valid;
    logic [31:0]             r_tdata;
    logic                    r_tlast;
    logic                    r_tuser;

    logic [DIM_W-1:0]        wid;
    logic [DIM_W-1:0]        hgt;
    logic [DIM_W-1:0]        hgt_m1;
    logic [DIM_W-1:0]        h_den;
    logic [DIM_W-1:0]        row_cl;
    logic [DIM_W-1:0]        h1;
    logic [1:0]              k_sel;
    logic                    is_step;
    logic [7:0]              top_b;
    logic [7:0]              bot_b;
    logic [DIM_W+7:0]        p1;
    logic [DIM_W+7:0]        p2;
    logic signed [8:0]       e_diff;
    logic [7:0]              mag;
    logic [NUM_W-1:0]        div_num;
    logic [DIM_W-1:0]        div_den;
    logic [NUM_W-1:0]        quo;
    logic                    div_done;
    logic                    same;
    logic signed [STEP_W-1:0] s_mag;
    logic signed [ACC_W-1:0] n_acc [4];
    logic [7:0]              n_chan [4];
    logic [4:0]              off [3];
    logic [3:0]              len_c [3];
    logic [3:0]              len [3];
    logic [3:0]              len_min;
    logic [31:0]             src;
    logic [7:0]              mask [3];
    logic [7:0]              fld [3];
    logic [7:0]              bgc [3];
    logic [15:0]             mixv [3];
    logic [16:0]             mixq [3];
    logic [7:0]              n_mix [3];
    logic [8:0]              dsum [3];
    logic [7:0]              dch [3];
    logic [31:0]             pix;
    logic [31:0]             val;
    logic                    eor;
    logic                    eob;
    logic [1:0]              depth;
    logic                    a0;
    logic                    yp;

    always_comb begin
        if (i_cfg.box_width == '0) begin
            wid = DIM_W'(1);
        end else if ({4'b0, i_cfg.box_width} > 17'(MAX_DIM)) begin
            wid = DIM_W'(MAX_DIM);
        end else begin
            wid = i_cfg.box_width;
        end
        if (i_cfg.box_height == '0) begin
            hgt = DIM_W'(1);
        end else if ({4'b0, i_cfg.box_height} > 17'(MAX_DIM)) begin
            hgt = DIM_W'(MAX_DIM);
        end else begin
            hgt = i_cfg.box_height;
        end
        hgt_m1 = hgt - DIM_W'(1);
        h_den  = (hgt > DIM_W'(1)) ? hgt_m1 : DIM_W'(1);
        row_cl = ({1'b0, r_row} < hgt_m1) ? {1'b0, r_row} : hgt_m1;
        h1     = hgt_m1 - row_cl;
    end

    always_comb begin
        is_step = i_cmd.div_idx[3];
        k_sel   = is_step ? i_cmd.div_idx[1:0] : i_cmd.div_idx[2:1];
        top_b   = i_cmd.div_idx[0] ? i_cfg.color_ur[8*k_sel +: 8] : i_cfg.color_ul[8*k_sel +: 8];
        bot_b   = i_cmd.div_idx[0] ? i_cfg.color_lr[8*k_sel +: 8] : i_cfg.color_ll[8*k_sel +: 8];
        p1      = h1 * top_b;
        p2      = row_cl * bot_b;
        e_diff  = $signed({1'b0, r_e2[k_sel]}) - $signed({1'b0, r_e1[k_sel]});
        mag     = e_diff[8] ? 8'(-e_diff) : e_diff[7:0];
        if (is_step) begin
            div_num = NUM_W'({mag, {FRAC_BITS{1'b0}}});
            div_den = wid;
        end else begin
            div_num = NUM_W'(p1) + NUM_W'(p2);
            div_den = h_den;
        end
        same = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (r_e1[k] != r_e2[k]) begin
                same = 1'b0;
            end
        end
        s_mag = $signed({1'b0, quo[8+FRAC_BITS-1:0]});
    end

    gbbd_divider #(
        .NUM_W(NUM_W),
        .DEN_W(DIM_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_quo  (quo),
        .o_done (div_done)
    );

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_acc[k] = r_acc[k] + ACC_W'(r_step[k]);
            if (n_acc[k] < 0) begin
                n_chan[k] = 8'd0;
            end else if ((n_acc[k] >>> FRAC_BITS) > 255) begin
                n_chan[k] = 8'd255;
            end else begin
                n_chan[k] = n_acc[k][FRAC_BITS +: 8];
            end
        end
    end

    always_comb begin
        depth = i_cfg.mode[1:0];
        for (int k = 0; k < 3; k++) begin
            off[k]   = i_cfg.layout[5*k +: 5];
            len_c[k] = (i_cfg.layout[15+4*k +: 4] > 4'd8) ? 4'd8 : i_cfg.layout[15+4*k +: 4];
        end
        len_min = len_c[0];
        if (len_c[1] < len_min) begin
            len_min = len_c[1];
        end
        if (len_c[2] < len_min) begin
            len_min = len_c[2];
        end
        for (int k = 0; k < 3; k++) begin
            len[k] = i_cfg.mode[2] ? len_min : len_c[k];
        end
        if (depth == DEPTH_16) begin
            src = {16'b0, r_bg[15:0]};
        end else if (depth == DEPTH_24) begin
            src = {8'b0, r_bg[23:0]};
        end else begin
            src = r_bg;
        end
        for (int k = 0; k < 3; k++) begin
            mask[k]  = 8'((9'd1 << len[k]) - 9'd1);
            fld[k]   = 8'(src >> off[k]) & mask[k];
            bgc[k]   = 8'(fld[k] << (4'd8 - len[k]));
            mixv[k]  = 16'(bgc[k]) * 16'(8'd255 - r_chan[3]) + 16'(r_chan[k]) * 16'(r_chan[3]);
            mixq[k]  = (17'(mixv[k]) + 17'd1 + 17'(mixv[k] >> 8)) >> 8;
            n_mix[k] = (r_chan[3] != 8'd255) ? mixq[k][7:0] : r_chan[k];
        end
    end

    always_comb begin
        dsum[0] = 9'(r_mix[0]) + 9'({r_phase, 1'b1});
        dsum[1] = 9'(r_mix[1]) + 9'(r_phase);
        dsum[2] = 9'(r_mix[2]) + 9'({r_phase, 1'b1});
        pix = '0;
        for (int k = 0; k < 3; k++) begin
            if (depth == DEPTH_16) begin
                dch[k] = dsum[k][8] ? 8'd255 : dsum[k][7:0];
            end else begin
                dch[k] = r_mix[k];
            end
            pix = pix | (32'(dch[k] >> (4'd8 - len[k])) << off[k]);
        end
        if (depth == DEPTH_16) begin
            val = {16'b0, pix[15:0]};
        end else if (depth == DEPTH_24) begin
            val = i_cfg.mode[3] ? {8'b0, pix[7:0], pix[15:8], pix[23:16]} : {8'b0, pix[23:0]};
        end else begin
            val = pix;
        end
        eor = {1'b0, r_col} >= (wid - DIM_W'(1));
        eob = eor && ({1'b0, r_row} >= hgt_m1);
        a0  = i_cfg.mode[4];
        yp  = i_cfg.mode[5] ^ r_row[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= '0;
            r_valid <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_acc[k]  <= '0;
                r_step[k] <= '0;
            end
        end else begin
            if (i_cmd.capture && i_first) begin
                r_col <= '0;
                r_row <= '0;
            end
            if (i_cmd.div_store && is_step) begin
                if (same) begin
                    r_step[k_sel] <= '0;
                end else begin
                    r_step[k_sel] <= e_diff[8] ? -s_mag : s_mag;
                end
            end
            if (i_cmd.row_init) begin
                for (int k = 0; k < 4; k++) begin
                    r_acc[k] <= $signed(ACC_W'({r_e1[k], {FRAC_BITS{1'b0}}}));
                end
                r_phase <= {1'b0, a0} ^ ((a0 ^ yp) ? 2'd1 : 2'd3);
            end
            if (i_cmd.acc_step) begin
                for (int k = 0; k < 4; k++) begin
                    r_acc[k] <= n_acc[k];
                end
            end
            if (i_cmd.commit) begin
                r_valid <= 1'b1;
                r_phase <= r_phase ^ 2'd3;
                if (eor) begin
                    r_col <= '0;
                    r_row <= eob ? '0 : r_row + CNT_W'(1);
                end else begin
                    r_col <= r_col + CNT_W'(1);
                end
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_bg <= i_bg;
        end
        if (i_cmd.div_store && !is_step) begin
            if (i_cmd.div_idx[0]) begin
                r_e2[k_sel] <= quo[7:0];
            end else begin
                r_e1[k_sel] <= quo[7:0];
            end
        end
        if (i_cmd.acc_step) begin
            for (int k = 0; k < 4; k++) begin
                r_chan[k] <= n_chan[k];
            end
        end
        if (i_cmd.blend) begin
            for (int k = 0; k < 3; k++) begin
                r_mix[k] <= n_mix[k];
            end
        end
        if (i_cmd.commit) begin
            r_tdata <= val;
            r_tlast <= eor;
            r_tuser <= eob;
        end
    end

    always_comb begin
        o_status.row_start = i_first || (r_col == '0);
        o_status.div_done  = div_done;
        o_status.out_free  = !r_valid || i_m_tready;
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tlast  = r_tlast;
    assign o_m_tuser  = r_tuser;

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_valid)
        else $error("Result register not loaded after a commit.");

    a_box_end_is_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_tuser) |-> r_tlast)
        else $error("End of box flagged without end of row.");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && eor) |=> (r_col == '0))
        else $error("Column count did not restart after the row end.");

endmodule

// ===== src/gbbd_ctrl.sv =====
module gbbd_ctrl
    import gbbd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state     r_state;
    t_state     n_state;
    logic [3:0] r_idx;
    logic [3:0] n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        o_cmd         = '0;
        o_cmd.div_idx = r_idx;
        o_s_tready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_idx         = '0;
                    n_state       = i_status.row_start ? S_DIV_GO : S_ACC;
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (r_idx == IDX_LAST) begin
                        n_idx   = '0;
                        n_state = S_ROW_INIT;
                    end else begin
                        n_idx   = r_idx + 4'd1;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_ROW_INIT: begin
                o_cmd.row_init = 1'b1;
                n_state        = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_step = 1'b1;
                n_state        = S_BLEND;
            end
            S_BLEND: begin
                o_cmd.blend = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_s_tvalid) |=> (r_state != S_IDLE))
        else $error("Transfer accepted but the controller stayed idle.");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_LAST)
        else $error("Division index out of range.");

    a_out_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> (r_state == S_OUT || r_state == S_IDLE))
        else $error("Controller left the output state wrongly.");

endmodule

// ===== verif/gradient_box_blend_dither_test.sv =====
module gradient_box_blend_dither_test;
    import gbbd_pkg::*;

    class gradient_scoreboard;
        bit [12:0] wid_reg, hgt_reg;
        bit [31:0] corner [4];
        bit [26:0] layout;
        bit [5:0]  mode;
        bit [11:0] col_cnt, row_cnt;
        longint    acc [4];
        longint    stp [4];
        bit [1:0]  phase;
        bit [33:0] pixel_q [$];
        int        errors;
        int        checked;

        function void reset_state();
            wid_reg = 1;
            hgt_reg = 1;
            foreach (corner[k]) corner[k] = 0;
            layout = LAYOUT_RESET;
            mode = 0;
            col_cnt = 0;
            row_cnt = 0;
            foreach (acc[k]) begin
                acc[k] = 0;
                stp[k] = 0;
            end
            phase = 0;
        endfunction

        function void write_reg(t_reg_idx idx, bit [31:0] v);
            case (idx)
                REG_BOX_WIDTH: wid_reg = v[12:0];
                REG_BOX_HEIGHT: hgt_reg = v[12:0];
                REG_COLOR_UL: corner[0] = v;
                REG_COLOR_UR: corner[1] = v;
                REG_COLOR_LL: corner[2] = v;
                REG_COLOR_LR: corner[3] = v;
                REG_LAYOUT: layout = v[26:0];
                REG_MODE: mode = v[5:0];
                default: ;
            endcase
        endfunction

        function int dim(bit [12:0] v);
            if (v == 0) return 1;
            if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
            return v;
        endfunction

        function void start_row();
            int     hgt, wid, h, row, h1, h2;
            longint e1 [4];
            longint e2 [4];
            longint d, mag, s;
            bit     same, a0, yp;
            hgt = dim(hgt_reg);
            wid = dim(wid_reg);
            h = hgt > 1 ? hgt - 1 : 1;
            row = row_cnt < hgt - 1 ? row_cnt : hgt - 1;
            h1 = (hgt - 1) - row;
            h2 = row;
            same = 1;
            for (int k = 0; k < 4; k++) begin
                e1[k] = (longint'(h1) * corner[0][8*k +: 8]
                         + longint'(h2) * corner[2][8*k +: 8]) / h;
                e2[k] = (longint'(h1) * corner[1][8*k +: 8]
                         + longint'(h2) * corner[3][8*k +: 8]) / h;
                if (e1[k] != e2[k]) same = 0;
            end
            for (int k = 0; k < 4; k++) begin
                d = e2[k] - e1[k];
                mag = d < 0 ? -d : d;
                s = (mag << FRAC_BITS_DEF) / wid;
                acc[k] = e1[k] << FRAC_BITS_DEF;
                stp[k] = same ? 0 : (d < 0 ? -s : s);
            end
            a0 = mode[4];
            yp = mode[5] ^ row_cnt[0];
            phase = {1'b0, a0} ^ ((a0 ^ yp) ? 2'd1 : 2'd3);
        endfunction

        function void note_pixel(bit [31:0] bg, bit first);
            int unsigned c [4];
            int unsigned off [3];
            int unsigned len [3];
            int unsigned m, src, mask, b;
            longint      t;
            bit [31:0]   pix, part, val;
            bit          eor, eob;
            if (first) begin
                col_cnt = 0;
                row_cnt = 0;
            end
            if (col_cnt == 0) start_row();
            for (int k = 0; k < 4; k++) begin
                acc[k] += stp[k];
                t = acc[k] < 0 ? 0 : (acc[k] >>> FRAC_BITS_DEF);
                c[k] = t > 255 ? 255 : int'(t);
            end
            for (int k = 0; k < 3; k++) begin
                off[k] = layout[5*k +: 5];
                len[k] = layout[15+4*k +: 4];
                if (len[k] > 8) len[k] = 8;
            end
            if (mode[2]) begin
                m = len[0];
                if (len[1] < m) m = len[1];
                if (len[2] < m) m = len[2];
                foreach (len[k]) len[k] = m;
            end
            if (c[3] != 255) begin
                src = mode[1:0] == DEPTH_16 ? (bg & 32'hffff)
                    : mode[1:0] == DEPTH_24 ? (bg & 32'hffffff) : bg;
                for (int k = 0; k < 3; k++) begin
                    mask = (32'd1 << len[k]) - 1;
                    b = ((src >> off[k]) & mask) << (8 - len[k]);
                    c[k] = (b * (255 - c[3]) + c[k] * c[3]) / 255;
                end
            end
            if (mode[1:0] == DEPTH_16) begin
                c[0] = c[0] + phase * 2 + 1;
                c[1] = c[1] + phase;
                c[2] = c[2] + phase * 2 + 1;
                for (int k = 0; k < 3; k++) if (c[k] > 255) c[k] = 255;
            end
            pix = 0;
            for (int k = 0; k < 3; k++) begin
                part = c[k] >> (8 - len[k]);
                pix |= part << off[k];
            end
            if (mode[1:0] == DEPTH_16) val = pix & 32'hffff;
            else if (mode[1:0] == DEPTH_24)
                val = mode[3] ? {8'd0, pix[7:0], pix[15:8], pix[23:16]}
                              : (pix & 32'hffffff);
            else val = pix;
            eor = col_cnt >= dim(wid_reg) - 1;
            eob = eor && row_cnt >= dim(hgt_reg) - 1;
            pixel_q.push_back({eob, eor, val});
            phase ^= 2'd3;
            if (eor) begin
                col_cnt = 0;
                row_cnt = eob ? 12'd0 : row_cnt + 12'd1;
            end else begin
                col_cnt = col_cnt + 12'd1;
            end
        endfunction

        function void check_pixel(bit [31:0] data, bit last, bit user);
            bit [33:0] e;
            checked++;
            if (pixel_q.size() == 0) begin
                $error("unexpected output pixel %h", data);
                errors++;
                return;
            end
            e = pixel_q.pop_front();
            if (data !== e[31:0]) begin
                $error("pixel_value expected %h actual %h", e[31:0], data);
                errors++;
            end
            if (last !== e[32]) begin
                $error("end_of_row expected %b actual %b", e[32], last);
                errors++;
            end
            if (user !== e[33]) begin
                $error("end_of_box expected %b actual %b", e[33], user);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk, i_rst_n;
    logic                  i_s_tvalid, o_s_tready;
    logic [31:0]           i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid, i_m_tready;
    logic [31:0]           o_m_tdata;
    logic                  o_m_tlast, o_m_tuser;
    logic                  psel, penable, pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata, prdata;
    logic                  pready;

    gradient_box_blend_dither dut (.*);

    gradient_scoreboard board = new();
    int  sent;
    int  hold_off;
    bit  no_idle;
    int  cycles;
    int  boxes;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 3000000) begin
            $display("[gradient_box_blend_dither] ERROR");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_pixel(o_m_tdata, o_m_tlast, o_m_tuser);
    end

    initial begin
        int g;
        i_m_tready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                i_m_tready = 0;
                hold_off--;
            end else if (no_idle) begin
                i_m_tready = 1;
            end else begin
                g = pick_gap();
                if (g > 0) begin
                    i_m_tready = 0;
                    repeat (g - 1) @(negedge i_clk);
                end else begin
                    i_m_tready = 1;
                end
            end
        end
    end

    task automatic apb_write(t_reg_idx idx, bit [31:0] v);
        @(negedge i_clk);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = CFG_ADDR_W'(4 * int'(idx));
        pwdata = v;
        @(negedge i_clk);
        penable = 1;
        do @(posedge i_clk); while (!pready);
        board.write_reg(idx, v);
        @(negedge i_clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    task automatic drain();
        while (board.pixel_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic configure(bit [12:0] w, bit [12:0] h, bit [31:0] ul, bit [31:0] ur,
                             bit [31:0] ll, bit [31:0] lr, bit [26:0] lay, bit [5:0] md);
        drain();
        apb_write(REG_BOX_WIDTH, {19'd0, w});
        apb_write(REG_BOX_HEIGHT, {19'd0, h});
        apb_write(REG_COLOR_UL, ul);
        apb_write(REG_COLOR_UR, ur);
        apb_write(REG_COLOR_LL, ll);
        apb_write(REG_COLOR_LR, lr);
        apb_write(REG_LAYOUT, {5'd0, lay});
        apb_write(REG_MODE, {26'd0, md});
    endtask

    task automatic send_pixel(bit [31:0] bg, bit first);
        int g;
        g = pick_gap();
        if (g > 0) begin
            i_s_tvalid = 0;
            repeat (g) @(negedge i_clk);
        end
        i_s_tvalid = 1;
        i_s_tdata = bg;
        i_s_tuser = first;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_pixel(bg, first);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_pixels(int n, bit first, int noise);
        for (int i = 0; i < n; i++)
            send_pixel($urandom(), (i == 0 && first) ||
                       ($urandom_range(0, 99) < noise));
        i_s_tvalid = 0;
    endtask

    function bit [31:0] pick_color();
        int r;
        bit [31:0] c;
        r = $urandom_range(0, 9);
        c = $urandom();
        if (r < 3) c[31:24] = 8'hff;
        else if (r < 4) c[31:24] = 8'h00;
        return c;
    endfunction

    initial begin
        bit [12:0] w, h;
        bit [26:0] lay;
        bit [31:0] c0;
        int        wi, hi, n, r;
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = 0;
        i_s_tuser = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        board.reset_state();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1;

        send_pixels(3, 1, 0);
        configure(0, 0, 32'hffffffff, 32'h0, 32'h80ff00ff, 32'h7f00ff00, LAYOUT_RESET, 6'h00);
        send_pixels(2, 1, 0);
        configure(4, 3, 32'hff0000ff, 32'hff00ff00, 32'hffff0000, 32'hffffffff,
                  27'h7ffffff, 6'h3f);
        send_pixels(12, 1, 0);
        configure(3, 2, 32'h00102030, 32'hff405060, 32'h80ffffff, 32'h01000000,
                  {4'd8, 4'd8, 4'd8, 5'd0, 5'd8, 5'd16}, 6'h09);
        send_pixels(6, 1, 0);
        c0 = 32'h40a0c0e0;
        configure(5, 2, c0, c0, c0, c0, {4'd8, 4'd8, 4'd8, 5'd16, 5'd8, 5'd0}, 6'h02);
        send_pixels(10, 1, 0);
        configure(8191, 4096, 32'h00000000, 32'hffffffff, 32'hff00ff00, 32'h00ff00ff,
                  {4'd5, 4'd6, 4'd5, 5'd11, 5'd5, 5'd0}, 6'h14);
        send_pixels(8, 1, 0);

        for (int p = 0; sent < 1100; p++) begin
            r = $urandom_range(0, 99);
            if (r < 8) w = 4096;
            else if (r < 11) w = r < 10 ? 13'd0 : 13'd8191;
            else w = $urandom_range(1, 12);
            r = $urandom_range(0, 99);
            h = r < 8 ? 13'd4096 : 13'($urandom_range(1, 6));
            r = $urandom_range(0, 3);
            lay = r == 0 ? LAYOUT_RESET
                : r == 1 ? {4'd8, 4'd8, 4'd8, 5'd16, 5'd8, 5'd0}
                : r == 2 ? {4'd8, 4'd8, 4'd8, 5'd0, 5'd8, 5'd16}
                : 27'($urandom());
            c0 = pick_color();
            if ($urandom_range(0, 7) == 0)
                configure(w, h, c0, c0, c0, c0, lay, 6'($urandom()));
            else
                configure(w, h, c0, pick_color(), pick_color(), pick_color(), lay,
                          6'($urandom()));
            no_idle = $urandom_range(0, 5) == 0;
            if (p == 3) hold_off = 600;
            wi = w == 0 ? 1 : (w > 4096 ? 4096 : w);
            hi = h;
            if (wi * hi <= 150 && p != 3) begin
                n = $urandom_range(1, 3);
                for (int b = 0; b < n; b++) begin
                    send_pixels(wi * hi, b > 0 || $urandom_range(0, 4) != 0,
                                $urandom_range(0, 3) == 0 ? 5 : 0);
                    boxes++;
                end
            end else begin
                send_pixels($urandom_range(10, 40), 1, 2);
            end
        end

        drain();
        $display("Sent %0d pixels in %0d full boxes, %0d results checked.",
                 sent, boxes, board.checked);
        $display("Covered 16/24/32 bpp, both endian modes, dither phases, blending and stalls.");
        if (board.errors == 0 && board.pixel_q.size() == 0) begin
            $display("[gradient_box_blend_dither] OK");
        end else begin
            $display("[gradient_box_blend_dither] ERROR");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/gbbd_pkg.sv
src/gbbd_divider.sv
src/gbbd_datapath.sv
src/gbbd_ctrl.sv
src/gradient_box_blend_dither.sv
verif/gradient_box_blend_dither_test.sv
